// ===== hw/rtl/asfc_pkg.sv =====
package asfc_pkg;

  localparam int AXES_MAX  = 3;
  localparam int MC_W      = 33;
  localparam int MP_W      = 17;
  localparam int PROD_W    = MC_W + MP_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [MP_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_BIAS_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCEL,
    ST_EMA_A,
    ST_EMA_R,
    ST_EMA_F,
    ST_PEAK,
    ST_OUT
  } asfc_state_t;

  typedef struct packed {
    logic                     start;
    logic signed [MC_W-1:0]   mcand;
    logic        [MP_W-1:0]   mplier;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh000000007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < 64'shFFFFFFFF80000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/asfc_serial_mult.sv =====
// Shift-add multiplier: one multiplier bit per cycle, signed multiplicand.
module asfc_serial_mult import asfc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int CNT_W = $clog2(MP_W + 1);

  logic signed [PROD_W-1:0] mc_r, mc_nxt, acc_r, acc_nxt;
  logic        [MP_W-1:0]   mp_r, mp_nxt;
  logic        [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    mc_nxt   = mc_r;
    acc_nxt  = acc_r;
    mp_nxt   = mp_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      mc_nxt   = {{(PROD_W-MC_W){req.mcand[MC_W-1]}}, req.mcand};
      mp_nxt   = req.mplier;
      acc_nxt  = '0;
      cnt_nxt  = CNT_W'(MP_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + (mp_r[0] ? mc_r : '0);
      mc_nxt  = mc_r <<< 1;
      mp_nxt  = mp_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    mc_r  <= mc_nxt;
    acc_r <= acc_nxt;
    mp_r  <= mp_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// ===== hw/rtl/accel_speed_filter_chain_unit.sv =====
// Three-axis acceleration to speed filter chain.
// Input channel: in_valid / in_stall with three raw ADC samples per item. The
// block stalls the input while it works on an item and takes the next one as
// soon as its result is in the output register, even if it has not been taken.
// Result channel: out_valid / out_stall, one result item per input item, held
// in an output register until the receiver lets it go. When the receiver
// stalls, the finished next item waits in the last step until the register
// frees up.
// Operation: every axis needs four products (scaling, then three averages),
// each made on one shared shift-add multiplier at one bit per cycle. The axes
// are done in turn, then the peak step and the result step; no new item is
// taken before the result is in the output register. The first item after
// reset only scales, which primes the filters.
// Configuration: cfg_valid / cfg_ready write one register by index; ready is
// always high, and writes are meant to happen while the block is idle.
// Reset (rst_n, synchronous, active low) restores the register defaults and
// marks the filters unprimed, so the next item primes them.
module accel_speed_filter_chain_unit import asfc_pkg::*; #(
  parameter int SAMPLE_BITS = 12,
  parameter int AXIS_COUNT  = 3,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample_x,
  input  logic [SAMPLE_BITS-1:0] in_sample_y,
  input  logic [SAMPLE_BITS-1:0] in_sample_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     out_smooth_accel_x,
  output logic signed [31:0]     out_smooth_accel_y,
  output logic signed [31:0]     out_smooth_accel_z,
  output logic signed [31:0]     out_speed_x,
  output logic signed [31:0]     out_speed_y,
  output logic signed [31:0]     out_speed_z,
  output logic signed [31:0]     out_peak_speed,
  output logic                   out_over_limit,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Scaling from the Q0.16 gain product to FRAC_BITS fraction bits.
  localparam int SH_L = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_R = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic [1:0] LAST_AX = 2'(AXIS_COUNT - 1);

  asfc_state_t state_r, state_nxt;

  logic [11:0]            bias_r [AXES_MAX];
  logic [15:0]            gain_r;
  logic [16:0]            alpha_r;
  logic [30:0]            limit_r;

  logic [SAMPLE_BITS-1:0] smp_r [AXES_MAX];
  logic [SAMPLE_BITS-1:0] smp_nxt [AXES_MAX];
  logic signed [31:0]     avg_r [AXES_MAX], avg_nxt [AXES_MAX];
  logic signed [31:0]     raw_r [AXES_MAX], raw_nxt [AXES_MAX];
  logic signed [31:0]     avr_r [AXES_MAX], avr_nxt [AXES_MAX];
  logic signed [31:0]     fin_r [AXES_MAX], fin_nxt [AXES_MAX];
  logic signed [31:0]     accv_r, accv_nxt, diff_r, diff_nxt;
  logic signed [31:0]     peak_r, peak_nxt;
  logic                   over_r, over_nxt;
  logic                   primed_r, primed_nxt;
  logic                   issued_r, issued_nxt;
  logic [1:0]             ax_r, ax_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic signed [31:0]     out_avg_r [AXES_MAX], out_avg_nxt [AXES_MAX];
  logic signed [31:0]     out_spd_r [AXES_MAX], out_spd_nxt [AXES_MAX];
  logic signed [31:0]     out_peak_r, out_peak_nxt;
  logic                   out_over_r, out_over_nxt;

  mul_req_t               req;
  mul_rsp_t               rsp;

  logic [16:0]            a_eff;
  logic [17:0]            dcount;
  logic signed [63:0]     pext, scaled;
  logic signed [31:0]     accv, ema_base, ema_new;
  logic [32:0]            m_fin, m_peak;

  asfc_serial_mult u_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Datapath pieces shared by the sequencer steps.
  always_comb begin
    a_eff  = (alpha_r > ONE_Q16) ? ONE_Q16 : alpha_r;
    dcount = 18'(smp_r[ax_r]) - 18'(bias_r[ax_r]);
    pext   = 64'(rsp.prod);
    scaled = (pext <<< SH_L) >>> SH_R;
    accv   = sat32(scaled);
    m_fin  = fin_r[0][31] ? (33'd0 - 33'(fin_r[0])) : 33'(fin_r[0]);
    m_peak = peak_r[31] ? (33'd0 - 33'(peak_r)) : 33'(peak_r);

    // Each average is avg + floor(alpha * (x - avg) / 2^16), which always
    // fits in 32 bits because it lies between x and avg.
    // A product is started on the first cycle of each multiply step.
    req.start  = 1'b0;
    req.mplier = a_eff;
    ema_base   = avg_r[ax_r];
    unique case (state_r)
      ST_ACCEL: begin
        req.start  = !issued_r;
        req.mcand  = 33'($signed(dcount));
        req.mplier = {1'b0, gain_r};
      end
      ST_EMA_A: begin
        req.start = !issued_r;
        req.mcand = 33'(accv_r) - 33'(avg_r[ax_r]);
        ema_base  = avg_r[ax_r];
      end
      ST_EMA_R: begin
        req.start = !issued_r;
        req.mcand = 33'(raw_r[ax_r]) - 33'(avr_r[ax_r]);
        ema_base  = avr_r[ax_r];
      end
      ST_EMA_F: begin
        req.start = !issued_r;
        req.mcand = 33'(diff_r) - 33'(fin_r[ax_r]);
        ema_base  = fin_r[ax_r];
      end
      default: begin
        req.mcand = '0;
      end
    endcase
    ema_new = rsp.prod[47:16] + ema_base;
  end

  // Sequencer: one product per step, axes in turn, then peak and result.
  always_comb begin
    state_nxt    = state_r;
    smp_nxt      = smp_r;
    avg_nxt      = avg_r;
    raw_nxt      = raw_r;
    avr_nxt      = avr_r;
    fin_nxt      = fin_r;
    accv_nxt     = accv_r;
    diff_nxt     = diff_r;
    peak_nxt     = peak_r;
    over_nxt     = over_r;
    primed_nxt   = primed_r;
    issued_nxt   = issued_r;
    ax_nxt       = ax_r;
    out_avg_nxt  = out_avg_r;
    out_spd_nxt  = out_spd_r;
    out_peak_nxt = out_peak_r;
    out_over_nxt = out_over_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          smp_nxt[0] = in_sample_x;
          smp_nxt[1] = in_sample_y;
          smp_nxt[2] = in_sample_z;
          ax_nxt     = '0;
          issued_nxt = 1'b0;
          state_nxt  = ST_ACCEL;
        end
      end
      ST_ACCEL, ST_EMA_A, ST_EMA_R, ST_EMA_F: begin
        if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (rsp.done) begin
          issued_nxt = 1'b0;
          case (state_r)
            ST_ACCEL: begin
              if (!primed_r) begin
                avg_nxt[ax_r] = accv;
                raw_nxt[ax_r] = '0;
                avr_nxt[ax_r] = '0;
                fin_nxt[ax_r] = '0;
                if (ax_r == LAST_AX) begin
                  state_nxt = ST_PEAK;
                end else begin
                  ax_nxt    = ax_r + 1'b1;
                  state_nxt = ST_ACCEL;
                end
              end else begin
                accv_nxt  = accv;
                state_nxt = ST_EMA_A;
              end
            end
            ST_EMA_A: begin
              avg_nxt[ax_r] = ema_new;
              raw_nxt[ax_r] = sat32(64'(raw_r[ax_r]) + 64'(accv_r) - 64'(ema_new));
              state_nxt     = ST_EMA_R;
            end
            ST_EMA_R: begin
              avr_nxt[ax_r] = ema_new;
              diff_nxt      = sat32(64'(raw_r[ax_r]) - 64'(ema_new));
              state_nxt     = ST_EMA_F;
            end
            default: begin
              fin_nxt[ax_r] = ema_new;
              if (ax_r == LAST_AX) begin
                state_nxt = ST_PEAK;
              end else begin
                ax_nxt    = ax_r + 1'b1;
                state_nxt = ST_ACCEL;
              end
            end
          endcase
        end
      end
      ST_PEAK: begin
        if (!primed_r) begin
          peak_nxt   = '0;
          over_nxt   = 1'b0;
          primed_nxt = 1'b1;
        end else begin
          if (m_fin > m_peak) begin
            peak_nxt = fin_r[0];
          end
          over_nxt = m_fin > {2'b00, limit_r};
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          for (int i = 0; i < AXES_MAX; i++) begin
            out_avg_nxt[i] = (i < AXIS_COUNT) ? avg_r[i] : '0;
            out_spd_nxt[i] = (i < AXIS_COUNT) ? fin_r[i] : '0;
          end
          out_peak_nxt  = peak_r;
          out_over_nxt  = over_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      primed_r    <= 1'b0;
      issued_r    <= 1'b0;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      primed_r    <= primed_nxt;
      issued_r    <= issued_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
    end
    smp_r      <= smp_nxt;
    avg_r      <= avg_nxt;
    raw_r      <= raw_nxt;
    avr_r      <= avr_nxt;
    fin_r      <= fin_nxt;
    accv_r     <= accv_nxt;
    diff_r     <= diff_nxt;
    peak_r     <= peak_nxt;
    over_r     <= over_nxt;
    out_avg_r  <= out_avg_nxt;
    out_spd_r  <= out_spd_nxt;
    out_peak_r <= out_peak_nxt;
    out_over_r <= out_over_nxt;
  end

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r[0] <= 12'd2048;
      bias_r[1] <= 12'd2048;
      bias_r[2] <= 12'd2048;
      gain_r    <= 16'd160;
      alpha_r   <= 17'd6554;
      limit_r   <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BIAS_X:      bias_r[0] <= cfg_data[11:0];
        REG_BIAS_Y:      bias_r[1] <= cfg_data[11:0];
        REG_BIAS_Z:      bias_r[2] <= cfg_data[11:0];
        REG_GAIN:        gain_r    <= cfg_data[15:0];
        REG_ALPHA:       alpha_r   <= cfg_data[16:0];
        REG_SPEED_LIMIT: limit_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready          = 1'b1;
  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_smooth_accel_x = out_avg_r[0];
  assign out_smooth_accel_y = out_avg_r[1];
  assign out_smooth_accel_z = out_avg_r[2];
  assign out_speed_x        = out_spd_r[0];
  assign out_speed_y        = out_spd_r[1];
  assign out_speed_z        = out_spd_r[2];
  assign out_peak_speed     = out_peak_r;
  assign out_over_limit     = out_over_r;

endmodule
